// ----- hw/rtl/dcs_pkg.sv -----
// ----------------------------------------------------------------------------
// dcs_pkg: shared constants for the distance constraint solver
// Fixed point widths and derived sizes of the solver datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package dcs_pkg;
  localparam int COORD_BITS = 32;
  localparam int DIFF_BITS  = COORD_BITS + 1;      // dx, dy signed
  localparam int MAG_BITS   = COORD_BITS;          // |dx|, |dy|
  localparam int SQ_BITS    = 2 * MAG_BITS + 1;    // dx^2 + dy^2
  localparam int DIST_BITS  = MAG_BITS + 1;        // sqrt result
  localparam int ERR_BITS   = DIST_BITS + 1;       // rest - dist, signed
  localparam int NUM_BITS   = MAG_BITS + DIST_BITS;  // |dc| * |err|
  localparam int DEN_BITS   = DIST_BITS + 1;       // dist or 2*dist
  localparam int QUO_BITS   = NUM_BITS + 1;        // quotient width

  typedef struct packed {
    logic                         valid;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic                         pa;
    logic                         pb;
    logic                         act;
    logic [COORD_BITS-2:0]        len;
  } item_t;
endpackage
`default_nettype wire

// ----- hw/rtl/distance_constraint_solver.sv -----
// ----------------------------------------------------------------------------
// distance_constraint_solver: pipelined Verlet distance constraint
// One spring-mesh edge per beat; corrected end positions out, saturated.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one edge per beat: both end
//   positions (signed Q16.16), pinned flags, active flag and rest length.
//   Output channel out_valid/out_stall returns one result per edge: the
//   corrected positions and the zero_distance flag, in input order.
//   Throughput: one edge per cycle while out_stall does not hold the pipeline.
//   A beat passes stages 1 to 3, the bit-per-stage square root (33 stages),
//   stages E and M, the restoring dividers (66 stages), one for x and one for y,
//   that run side by side, then stage A and the output register.
//   The pipeline advances as one unit: when the output register holds a beat
//   and out_stall is high, every stage holds and in_stall is raised; empty
//   stages are not squeezed out, they hold along with the beats around them,
//   and a beat may enter whenever the output register is free to move.
//   Reset clears all valid bits; the block takes a beat in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module distance_constraint_solver (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [dcs_pkg::COORD_BITS-1:0]  end_a_x,
  input  wire logic signed [dcs_pkg::COORD_BITS-1:0]  end_a_y,
  input  wire logic signed [dcs_pkg::COORD_BITS-1:0]  end_b_x,
  input  wire logic signed [dcs_pkg::COORD_BITS-1:0]  end_b_y,
  input  wire logic                                   end_a_pinned,
  input  wire logic                                   end_b_pinned,
  input  wire logic                                   edge_active,
  input  wire logic [dcs_pkg::COORD_BITS-2:0]         rest_length,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [dcs_pkg::COORD_BITS-1:0]       new_a_x,
  output logic signed [dcs_pkg::COORD_BITS-1:0]       new_a_y,
  output logic signed [dcs_pkg::COORD_BITS-1:0]       new_b_x,
  output logic signed [dcs_pkg::COORD_BITS-1:0]       new_b_y,
  output logic                                        zero_distance
);
  localparam int CB  = dcs_pkg::COORD_BITS;
  localparam int MB  = dcs_pkg::MAG_BITS;
  localparam int SB  = dcs_pkg::SQ_BITS;
  localparam int DB  = dcs_pkg::DIST_BITS;
  localparam int EB  = dcs_pkg::ERR_BITS;
  localparam int NB  = dcs_pkg::NUM_BITS;
  localparam int NDB = dcs_pkg::DEN_BITS;
  localparam int QB  = dcs_pkg::QUO_BITS;
  localparam int SQRT_STEPS = DB;
  localparam int SQRT_RB    = SB + 2;   // remainder width
  localparam int DIV_RB     = NDB + 1;

  // pipeline advance
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ---------------- stage 1: differences and magnitudes ----------------
  dcs_pkg::item_t                 s1_it;
  logic signed [CB:0]             s1_dx, s1_dy;
  logic [MB-1:0]                  s1_mx, s1_my;
  logic signed [CB:0]             dx_c, dy_c;
  logic [CB:0]                    mdx_c, mdy_c;

  always_comb begin
    dx_c  = {end_a_x[CB-1], end_a_x} - {end_b_x[CB-1], end_b_x};
    dy_c  = {end_a_y[CB-1], end_a_y} - {end_b_y[CB-1], end_b_y};
    mdx_c = dx_c[CB] ? (~dx_c + 1'b1) : dx_c;
    mdy_c = dy_c[CB] ? (~dy_c + 1'b1) : dy_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_it.valid <= 1'b0;
    end else if (adv) begin
      s1_it.valid <= in_valid;
    end
    if (adv) begin
      s1_it.ax  <= end_a_x;
      s1_it.ay  <= end_a_y;
      s1_it.bx  <= end_b_x;
      s1_it.by  <= end_b_y;
      s1_it.pa  <= end_a_pinned;
      s1_it.pb  <= end_b_pinned;
      s1_it.act <= edge_active;
      s1_it.len <= rest_length;
      s1_dx     <= dx_c;
      s1_dy     <= dy_c;
      s1_mx     <= mdx_c[MB-1:0];
      s1_my     <= mdy_c[MB-1:0];
    end
  end

  // ---------------- stage 2: squares ----------------
  dcs_pkg::item_t       s2_it;
  logic signed [CB:0]   s2_dx, s2_dy;
  logic [2*MB-1:0]      s2_px, s2_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_it.valid <= 1'b0;
    end else if (adv) begin
      s2_it.valid <= s1_it.valid;
    end
    if (adv) begin
      s2_it.ax  <= s1_it.ax;
      s2_it.ay  <= s1_it.ay;
      s2_it.bx  <= s1_it.bx;
      s2_it.by  <= s1_it.by;
      s2_it.pa  <= s1_it.pa;
      s2_it.pb  <= s1_it.pb;
      s2_it.act <= s1_it.act;
      s2_it.len <= s1_it.len;
      s2_dx     <= s1_dx;
      s2_dy     <= s1_dy;
      s2_px     <= s1_mx * s1_mx;
      s2_py     <= s1_my * s1_my;
    end
  end

  // ---------------- stage 3: sum of squares ----------------
  dcs_pkg::item_t       s3_it;
  logic signed [CB:0]   s3_dx, s3_dy;
  logic [SB-1:0]        s3_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_it <= '0;
    end else if (adv) begin
      s3_it <= s2_it;
    end
    if (adv) begin
      s3_dx  <= s2_dx;
      s3_dy  <= s2_dy;
      s3_sum <= {1'b0, s2_px} + {1'b0, s2_py};
    end
  end

  // ---------------- square root: one result bit per stage ----------------
  // restoring: rem holds s - r^2 of bits consumed so far; stage k takes two
  // bits of the radicand
  localparam int SQ_PAD = 2 * SQRT_STEPS;
  dcs_pkg::item_t       sq_it  [SQRT_STEPS+1];
  logic signed [CB:0]   sq_dx  [SQRT_STEPS+1];
  logic signed [CB:0]   sq_dy  [SQRT_STEPS+1];
  logic [SQ_PAD-1:0]    sq_rad [SQRT_STEPS+1];
  logic [SQRT_RB-1:0]   sq_rem [SQRT_STEPS+1];
  logic [DB-1:0]        sq_root[SQRT_STEPS+1];

  always_comb begin
    sq_it[0]   = s3_it;
    sq_dx[0]   = s3_dx;
    sq_dy[0]   = s3_dy;
    sq_rad[0]  = SQ_PAD'(s3_sum);
    sq_rem[0]  = '0;
    sq_root[0] = '0;
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [SQRT_RB-1:0] rem_sh, trial;
    logic               ok;
    always_comb begin
      rem_sh = {sq_rem[k][SQRT_RB-3:0], sq_rad[k][SQ_PAD-1 -: 2]};
      trial  = {sq_root[k], 2'b01};
      ok     = rem_sh >= trial;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_it[k+1] <= '0;
      end else if (adv) begin
        sq_it[k+1] <= sq_it[k];
      end
      if (adv) begin
        sq_dx[k+1]   <= sq_dx[k];
        sq_dy[k+1]   <= sq_dy[k];
        sq_rad[k+1]  <= {sq_rad[k][SQ_PAD-3:0], 2'b00};
        sq_rem[k+1]  <= ok ? (rem_sh - trial) : rem_sh;
        sq_root[k+1] <= {sq_root[k][DB-2:0], ok};
      end
    end
  end

  // ---------------- stage E: error, denominator, signs ----------------
  dcs_pkg::item_t       e_it;
  logic                 e_do, e_zero;
  logic [NDB-1:0]       e_den;
  logic [MB-1:0]        e_mx, e_my;
  logic [DB:0]          e_merr;
  logic                 e_sx, e_sy;
  logic signed [EB-1:0] err_c;
  logic [EB-1:0]        merr_c;
  logic [CB:0]          mx_c, my_c;
  logic                 do_c;
  dcs_pkg::item_t       t_it;
  logic [DB-1:0]        t_dist;

  always_comb begin
    t_it   = sq_it[SQRT_STEPS];
    t_dist = sq_root[SQRT_STEPS];
    do_c   = t_it.act && !(t_it.pa && t_it.pb);
    err_c  = $signed({2'b00, t_it.len}) - $signed({1'b0, t_dist});
    merr_c = err_c[EB-1] ? (~err_c + 1'b1) : err_c;
    mx_c   = sq_dx[SQRT_STEPS][CB] ? (~sq_dx[SQRT_STEPS] + 1'b1) : sq_dx[SQRT_STEPS];
    my_c   = sq_dy[SQRT_STEPS][CB] ? (~sq_dy[SQRT_STEPS] + 1'b1) : sq_dy[SQRT_STEPS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_it <= '0;
    end else if (adv) begin
      e_it <= t_it;
    end
    if (adv) begin
      e_do   <= do_c && (t_dist != '0);
      e_zero <= do_c && (t_dist == '0);
      e_den  <= (t_it.pa || t_it.pb) ? {1'b0, t_dist} : {t_dist, 1'b0};
      e_mx   <= mx_c[MB-1:0];
      e_my   <= my_c[MB-1:0];
      e_merr <= merr_c[DB:0];
      e_sx   <= sq_dx[SQRT_STEPS][CB] ^ err_c[EB-1];
      e_sy   <= sq_dy[SQRT_STEPS][CB] ^ err_c[EB-1];
    end
  end

  // ---------------- stage M: products plus rounding half ----------------
  dcs_pkg::item_t   m_it;
  logic             m_do, m_zero, m_sx, m_sy;
  logic [NDB-1:0]   m_den;
  logic [QB-1:0]    m_nx, m_ny;
  logic [NB-1:0]    px_c, py_c;

  always_comb begin
    px_c = e_mx * e_merr[DB-1:0];
    py_c = e_my * e_merr[DB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_it <= '0;
    end else if (adv) begin
      m_it <= e_it;
    end
    if (adv) begin
      m_do   <= e_do;
      m_zero <= e_zero;
      m_sx   <= e_sx;
      m_sy   <= e_sy;
      m_den  <= e_den;
      m_nx   <= QB'(px_c) + QB'(e_den >> 1);
      m_ny   <= QB'(py_c) + QB'(e_den >> 1);
    end
  end

  // ---------------- restoring dividers, x and y, one bit per stage ----------------
  dcs_pkg::item_t   dv_it  [QB+1];
  logic             dv_do  [QB+1];
  logic             dv_zero[QB+1];
  logic             dv_sx  [QB+1];
  logic             dv_sy  [QB+1];
  logic [NDB-1:0]   dv_den [QB+1];
  logic [QB-1:0]    dv_nx  [QB+1];
  logic [QB-1:0]    dv_ny  [QB+1];
  logic [DIV_RB-1:0] dv_rx [QB+1];
  logic [DIV_RB-1:0] dv_ry [QB+1];

  always_comb begin
    dv_it[0]   = m_it;
    dv_do[0]   = m_do;
    dv_zero[0] = m_zero;
    dv_sx[0]   = m_sx;
    dv_sy[0]   = m_sy;
    dv_den[0]  = m_den;
    dv_nx[0]   = m_nx;
    dv_ny[0]   = m_ny;
    dv_rx[0]   = '0;
    dv_ry[0]   = '0;
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [DIV_RB-1:0] rx_sh, ry_sh;
    logic              qx, qy;
    always_comb begin
      rx_sh = {dv_rx[k][DIV_RB-2:0], dv_nx[k][QB-1]};
      ry_sh = {dv_ry[k][DIV_RB-2:0], dv_ny[k][QB-1]};
      qx    = rx_sh >= {1'b0, dv_den[k]};
      qy    = ry_sh >= {1'b0, dv_den[k]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_it[k+1] <= '0;
      end else if (adv) begin
        dv_it[k+1] <= dv_it[k];
      end
      if (adv) begin
        dv_do[k+1]   <= dv_do[k];
        dv_zero[k+1] <= dv_zero[k];
        dv_sx[k+1]   <= dv_sx[k];
        dv_sy[k+1]   <= dv_sy[k];
        dv_den[k+1]  <= dv_den[k];
        dv_rx[k+1]   <= qx ? (rx_sh - {1'b0, dv_den[k]}) : rx_sh;
        dv_ry[k+1]   <= qy ? (ry_sh - {1'b0, dv_den[k]}) : ry_sh;
        dv_nx[k+1]   <= {dv_nx[k][QB-2:0], qx};
        dv_ny[k+1]   <= {dv_ny[k][QB-2:0], qy};
      end
    end
  end

  // ---------------- stage A: apply offsets ----------------
  localparam int WB = QB + 2;
  dcs_pkg::item_t  f_it;
  logic            f_zero;
  logic signed [WB-1:0] f_ax, f_ay, f_bx, f_by;
  logic signed [WB-1:0] ox_c, oy_c;
  dcs_pkg::item_t  g_it;
  logic            g_do, g_zero;

  always_comb begin
    g_it   = dv_it[QB];
    g_do   = dv_do[QB];
    g_zero = dv_zero[QB];
    ox_c   = dv_sx[QB] ? -$signed({2'b00, dv_nx[QB]}) : $signed({2'b00, dv_nx[QB]});
    oy_c   = dv_sy[QB] ? -$signed({2'b00, dv_ny[QB]}) : $signed({2'b00, dv_ny[QB]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_it <= '0;
    end else if (adv) begin
      f_it <= g_it;
    end
    if (adv) begin
      f_zero <= g_zero;
      f_ax   <= WB'(g_it.ax) + ((g_do && !g_it.pa) ? ox_c : '0);
      f_ay   <= WB'(g_it.ay) + ((g_do && !g_it.pa) ? oy_c : '0);
      f_bx   <= WB'(g_it.bx) - ((g_do && !g_it.pb) ? ox_c : '0);
      f_by   <= WB'(g_it.by) - ((g_do && !g_it.pb) ? oy_c : '0);
    end
  end

  // ---------------- output register with saturation ----------------
  localparam logic signed [WB-1:0] MAXV = WB'({1'b0, {(CB-1){1'b1}}});
  localparam logic signed [WB-1:0] MINV = -MAXV - WB'(1);

  function automatic logic [CB-1:0] sat(input logic signed [WB-1:0] v);
    logic [CB-1:0] r;
    if (v > MAXV) begin
      r = {1'b0, {(CB-1){1'b1}}};
    end else if (v < MINV) begin
      r = {1'b1, {(CB-1){1'b0}}};
    end else begin
      r = v[CB-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= f_it.valid;
    end
    if (adv) begin
      new_a_x       <= sat(f_ax);
      new_a_y       <= sat(f_ay);
      new_b_x       <= sat(f_bx);
      new_b_y       <= sat(f_by);
      zero_distance <= f_zero;
    end
  end

  // ---------------- assertions ----------------
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(new_a_x) && $stable(new_b_y)))
    else $error("output beat changed under stall");
  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output stall");
  a_zero_pass: assert property (@(posedge clk) disable iff (rst)
    (f_it.valid && f_zero && adv) |=> (new_a_x == $past(f_it.ax) && new_b_x == $past(f_it.bx)))
    else $error("zero distance moved a position");
  a_zero_do: assert property (@(posedge clk) disable iff (rst)
    (e_it.valid) |-> !(e_do && e_zero))
    else $error("correction and zero flag both set");
endmodule
`default_nettype wire

// ----- tb/sv/distance_constraint_solver_test.sv -----
// ----------------------------------------------------------------------------
// distance_constraint_solver_test: self-checking bench for the edge solver
// Drives mesh edges through the valid/stall input channel, predicts the
// corrected positions with an in-bench fixed point model and compares every
// result beat in order, under random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module distance_constraint_solver_test;

  typedef struct {
    logic signed [dcs_pkg::COORD_BITS-1:0] ax, ay, bx, by;
    logic zd;
  } edge_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [dcs_pkg::COORD_BITS-1:0] end_a_x = '0, end_a_y = '0;
  logic signed [dcs_pkg::COORD_BITS-1:0] end_b_x = '0, end_b_y = '0;
  logic end_a_pinned = 1'b0, end_b_pinned = 1'b0, edge_active = 1'b0;
  logic [dcs_pkg::COORD_BITS-2:0] rest_length = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [dcs_pkg::COORD_BITS-1:0] new_a_x, new_a_y, new_b_x, new_b_y;
  logic zero_distance;

  edge_result_t pending_edges[$];
  int errors = 0;
  bit quiet = 0;
  int hold_cycles = 0;

  distance_constraint_solver dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [127:0] isqrt(logic [127:0] s);
    logic [127:0] r;
    logic [127:0] c;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [127:0] pull_offset(logic signed [127:0] dc,
                                                      logic signed [127:0] err,
                                                      logic [127:0] den);
    logic [127:0] n;
    logic [127:0] q;
    n = (dc < 0 ? -dc : dc) * (err < 0 ? -err : err);
    q = (n + (den >> 1)) / den;
    return ((dc < 0) != (err < 0)) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [dcs_pkg::COORD_BITS-1:0] clamp(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[dcs_pkg::COORD_BITS-1:0];
  endfunction

  function automatic edge_result_t solve_edge(logic signed [31:0] ax, ay, bx, by,
                                              logic pa, pb, act, logic [30:0] len);
    edge_result_t r;
    logic signed [127:0] xa, ya, xb, yb, dx, dy, err, ox, oy;
    logic [127:0] edge_len, den;
    xa = ax; ya = ay; xb = bx; yb = by;
    r.zd = 1'b0;
    if (act && !(pa && pb)) begin
      dx = xa - xb;
      dy = ya - yb;
      edge_len = isqrt(dx * dx + dy * dy);
      if (edge_len == 0) begin
        r.zd = 1'b1;
      end else begin
        err = $signed({97'd0, len}) - $signed(edge_len);
        den = (pa || pb) ? edge_len : edge_len * 2;
        ox = pull_offset(dx, err, den);
        oy = pull_offset(dy, err, den);
        if (!pa) begin xa = xa + ox; ya = ya + oy; end
        if (!pb) begin xb = xb - ox; yb = yb - oy; end
      end
    end
    r.ax = clamp(xa); r.ay = clamp(ya); r.bx = clamp(xb); r.by = clamp(yb);
    return r;
  endfunction

  task automatic send_edge(logic signed [31:0] ax, ay, bx, by,
                           logic pa, pb, act, logic [30:0] len);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    end_a_x <= ax; end_a_y <= ay; end_b_x <= bx; end_b_y <= by;
    end_a_pinned <= pa; end_b_pinned <= pb; edge_active <= act; rest_length <= len;
    pending_edges.push_back(solve_edge(ax, ay, bx, by, pa, pb, act, len));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
    endcase
  endfunction

  task automatic send_random_edge();
    logic signed [31:0] ax, ay;
    logic [30:0] len;
    ax = rand_coord();
    ay = rand_coord();
    len = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h01000000));
    if ($urandom_range(0, 19) == 0)
      send_edge(ax, ay, ax, ay, 1'($urandom), 1'($urandom), 1'($urandom), len);
    else
      send_edge(ax, ay, rand_coord(), rand_coord(), $urandom_range(0, 3) == 0,
                $urandom_range(0, 3) == 0, $urandom_range(0, 7) != 0, len);
  endtask

  task automatic wait_drained();
    idle_input();
    while (pending_edges.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_edge(0, 0, 32'sh00030000, 32'sh00040000, 1'b0, 1'b0, 1'b1, 31'h000a0000);
    send_edge(0, 0, 32'sh00030000, 32'sh00040000, 1'b1, 1'b0, 1'b1, 31'h00020000);
    send_edge(0, 0, 32'sh00030000, 32'sh00040000, 1'b0, 1'b1, 1'b1, 31'h00020000);
    send_edge(0, 0, 32'sh00030000, 32'sh00040000, 1'b1, 1'b1, 1'b1, 31'h00020000);
    send_edge(0, 0, 32'sh00030000, 32'sh00040000, 1'b0, 1'b0, 1'b0, 31'h00020000);
    send_edge(32'sh00050000, 7, 32'sh00050000, 7, 1'b0, 1'b0, 1'b1, 31'h00010000);
    send_edge(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
              1'b0, 1'b0, 1'b1, 31'h0);
    send_edge(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
              1'b0, 1'b0, 1'b1, 31'h7fffffff);
    send_edge(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
              1'b1, 1'b0, 1'b1, 31'h0);
    send_edge(32'sh7fffffff, 0, 32'sh7ffffff0, 0, 1'b0, 1'b0, 1'b1, 31'h7fffffff);
    send_edge(32'sh80000000, 0, 32'sh80000010, 0, 1'b0, 1'b1, 1'b1, 31'h7fffffff);
    send_edge(-1, -1, 1, 1, 1'b0, 1'b0, 1'b1, 31'h7fffffff);
    send_edge(1, 0, 0, 0, 1'b0, 1'b0, 1'b1, 31'h0);
    send_edge(32'shffffffff, 32'sh55555555, 32'shaaaaaaaa, 0, 1'b0, 1'b0, 1'b1,
              31'h55555555);
    send_edge(3, 4, 0, 0, 1'b0, 1'b0, 1'b1, 31'h2aaaaaaa);
    wait_drained();
  endtask

  task automatic test_random();
    repeat (1000) send_random_edge();
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    repeat (200) send_random_edge();
    wait_drained();
  endtask

  task automatic test_full_rate();
    quiet = 1;
    repeat (150) send_random_edge();
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    edge_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_edges.size() == 0) begin
        $display("%t unexpected beat a=(%h,%h) b=(%h,%h)", $time,
                 new_a_x, new_a_y, new_b_x, new_b_y);
        errors++;
      end else begin
        e = pending_edges.pop_front();
        if ({e.ax, e.ay, e.bx, e.by, e.zd} !==
            {new_a_x, new_a_y, new_b_x, new_b_y, zero_distance}) begin
          $display("%t mismatch expected a=(%h,%h) b=(%h,%h) z=%b actual a=(%h,%h) b=(%h,%h) z=%b",
                   $time, e.ax, e.ay, e.bx, e.by, e.zd,
                   new_a_x, new_a_y, new_b_x, new_b_y, zero_distance);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    test_full_rate();
    repeat (150) @(posedge clk);
    if (errors == 0 && pending_edges.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
